// ----- rtl/grd_pkg.sv -----
package grd_pkg;

  // Defaults for the top level parameters
  localparam int RATIO_SHIFT_DEF = 16;
  localparam int GEAR_COUNT_DEF  = 6;

  // Field widths
  localparam int SPEED_W    = 16;
  localparam int RATIO_W    = 16;
  localparam int GEAR_W     = 3;
  localparam int WIN_W      = 64;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GEAR1_WIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD    = 3'd6;

  // Reported gear codes
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL  = 3'd0;
  localparam logic [GEAR_W-1:0] GEAR_CLUTCHED = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic start;  // latch request, apply tick, launch divide
    logic load;   // commit gear state and fill the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  // Window word layout
  function automatic logic [RATIO_W-1:0] win_inner_lo(input logic [WIN_W-1:0] w);
    return w[15:0];
  endfunction

  function automatic logic [RATIO_W-1:0] win_inner_hi(input logic [WIN_W-1:0] w);
    return w[31:16];
  endfunction

  function automatic logic [RATIO_W-1:0] win_outer_lo(input logic [WIN_W-1:0] w);
    return w[47:32];
  endfunction

  function automatic logic [RATIO_W-1:0] win_outer_hi(input logic [WIN_W-1:0] w);
    return w[63:48];
  endfunction

endpackage

// ----- rtl/grd_in_if.sv -----
interface grd_in_if;
  logic                         valid;
  logic                         ready;
  logic [grd_pkg::SPEED_W-1:0]  vehicle_speed;
  logic [grd_pkg::SPEED_W-1:0]  engine_speed;
  logic                         vehicle_moving;
  logic                         engine_stopped;
  logic                         clutch_down;
  logic                         decay_tick;

  modport source (
    output valid, vehicle_speed, engine_speed, vehicle_moving, engine_stopped,
           clutch_down, decay_tick,
    input  ready
  );

  modport sink (
    input  valid, vehicle_speed, engine_speed, vehicle_moving, engine_stopped,
           clutch_down, decay_tick,
    output ready
  );
endinterface

// ----- rtl/grd_out_if.sv -----
interface grd_out_if;
  logic                        valid;
  logic                        ready;
  logic [grd_pkg::GEAR_W-1:0]  reported_gear;
  logic [grd_pkg::GEAR_W-1:0]  detected_gear;
  logic [grd_pkg::RATIO_W-1:0] gear_ratio;
  logic                        gear_unstable;

  modport source (
    output valid, reported_gear, detected_gear, gear_ratio, gear_unstable,
    input  ready
  );

  modport sink (
    input  valid, reported_gear, detected_gear, gear_ratio, gear_unstable,
    output ready
  );
endinterface

// ----- rtl/grd_cfg_if.sv -----
interface grd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [grd_pkg::CFG_IDX_W-1:0]  index;
  logic [grd_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/grd_div.sv -----
// Serial divider: (dividend << RATIO_SHIFT) / divisor, saturated to 16 bits.
// Overflow (and zero divisor) is caught up front; otherwise one quotient bit a cycle.
module grd_div #(
  parameter int RATIO_SHIFT = grd_pkg::RATIO_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [grd_pkg::SPEED_W-1:0] dividend,
  input  logic [grd_pkg::SPEED_W-1:0] divisor,
  output logic                        done,
  output logic [grd_pkg::RATIO_W-1:0] quotient
);

  localparam int QW     = grd_pkg::RATIO_W;
  localparam int NUM_W  = grd_pkg::SPEED_W + RATIO_SHIFT;
  localparam int CMP_W  = grd_pkg::SPEED_W + QW;
  localparam int ITER_W = $clog2(QW);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [QW-1:0]     rem_r;
  logic [QW-1:0]     low_r;
  logic [QW-1:0]     dvs_r;

  logic [NUM_W-1:0]  num;
  logic [CMP_W-1:0]  num_ext;
  logic              sat;
  logic [QW:0]       rem2;
  logic [QW:0]       diff;
  logic              ge;

  assign num     = {dividend, {RATIO_SHIFT{1'b0}}};
  assign num_ext = CMP_W'(num);
  // quotient would not fit 16 bits (also true for a zero divisor)
  assign sat     = num_ext >= {divisor, {QW{1'b0}}};

  assign rem2 = {rem_r, low_r[QW-1]};
  assign diff = rem2 - {1'b0, dvs_r};
  assign ge   = rem2 >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= start ? sat : (busy_r && iter_r == ITER_W'(QW - 1));
      if (start) begin
        iter_r <= '0;
        busy_r <= !sat;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
        if (iter_r == ITER_W'(QW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      if (sat) begin
        low_r <= {QW{1'b1}};
      end else begin
        rem_r <= QW'(num[NUM_W-1:QW]);
        low_r <= num[QW-1:0];
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[QW-1:0] : rem2[QW-1:0];
      low_r <= {low_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = low_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");

endmodule

// ----- rtl/grd_dp.sv -----
// Datapath: config registers, divider, gear selection, gear state, output register.
module grd_dp #(
  parameter int RATIO_SHIFT = grd_pkg::RATIO_SHIFT_DEF,
  parameter int GEAR_COUNT  = grd_pkg::GEAR_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write
  input  logic                           cfg_we,
  input  logic [grd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grd_pkg::CFG_DATA_W-1:0] cfg_data,
  // request payload
  input  logic [grd_pkg::SPEED_W-1:0]    vehicle_speed,
  input  logic [grd_pkg::SPEED_W-1:0]    engine_speed,
  input  logic                           vehicle_moving,
  input  logic                           engine_stopped,
  input  logic                           clutch_down,
  input  logic                           decay_tick,
  // control
  input  grd_pkg::dp_cmd_t               cmd,
  output grd_pkg::dp_sts_t               sts,
  // result payload
  output logic [grd_pkg::GEAR_W-1:0]     reported_gear,
  output logic [grd_pkg::GEAR_W-1:0]     detected_gear,
  output logic [grd_pkg::RATIO_W-1:0]    gear_ratio,
  output logic                           gear_unstable
);

  localparam int GW = grd_pkg::GEAR_W;
  localparam int RW = grd_pkg::RATIO_W;
  localparam int CW = grd_pkg::CNT_W;

  logic [grd_pkg::WIN_W-1:0] win_r [GEAR_COUNT];
  logic [CW-1:0]             reload_r;

  logic [GW-1:0] calc_gear_r;
  logic [CW-1:0] count_r;
  logic [GW-1:0] shown_r;

  logic moving_r;
  logic stopped_r;
  logic clutch_r;

  logic [GW-1:0] rep_r;
  logic [GW-1:0] det_r;
  logic [RW-1:0] ratio_r;
  logic          unst_r;

  logic          div_done;
  logic [RW-1:0] ratio;

  logic          held_ok;
  logic [GW-1:0] srch_gear;
  logic [GW-1:0] next_gear;
  logic [CW-1:0] count_new;
  logic [GW-1:0] shown_new;

  grd_div #(
    .RATIO_SHIFT (RATIO_SHIFT)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (vehicle_speed),
    .divisor  (engine_speed),
    .done     (div_done),
    .quotient (ratio)
  );

  assign sts.div_done = div_done;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GEAR_COUNT; g++) begin
        win_r[g] <= '0;
      end
      reload_r <= '0;
    end else if (cfg_we) begin
      for (int g = 0; g < GEAR_COUNT; g++) begin
        if (cfg_index == grd_pkg::REG_GEAR1_WIN + grd_pkg::CFG_IDX_W'(g)) begin
          win_r[g] <= cfg_data;
        end
      end
      if (cfg_index == grd_pkg::REG_RELOAD) begin
        reload_r <= cfg_data[CW-1:0];
      end
    end
  end

  // gear selection: hold inside the outer window, else first inner match
  always_comb begin
    held_ok   = 1'b0;
    srch_gear = grd_pkg::GEAR_NEUTRAL;
    for (int g = 0; g < GEAR_COUNT; g++) begin
      if (calc_gear_r == GW'(g + 1) &&
          ratio > grd_pkg::win_outer_lo(win_r[g]) &&
          ratio < grd_pkg::win_outer_hi(win_r[g])) begin
        held_ok = 1'b1;
      end
    end
    for (int g = GEAR_COUNT - 1; g >= 0; g--) begin
      if (ratio > grd_pkg::win_inner_lo(win_r[g]) &&
          ratio < grd_pkg::win_inner_hi(win_r[g])) begin
        srch_gear = GW'(g + 1);
      end
    end
    next_gear = held_ok ? calc_gear_r : srch_gear;
    count_new = (next_gear != calc_gear_r) ? reload_r : count_r;
    if (!moving_r || stopped_r) begin
      shown_new = grd_pkg::GEAR_NEUTRAL;
    end else if (clutch_r) begin
      shown_new = grd_pkg::GEAR_CLUTCHED;
    end else if (count_new == '0) begin
      shown_new = next_gear;
    end else begin
      shown_new = shown_r;
    end
  end

  // gear state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_gear_r <= grd_pkg::GEAR_NEUTRAL;
      count_r     <= '0;
      shown_r     <= grd_pkg::GEAR_NEUTRAL;
    end else if (cmd.start) begin
      if (decay_tick && count_r != '0) begin
        count_r <= count_r - 1'b1;
      end
    end else if (cmd.load) begin
      calc_gear_r <= next_gear;
      count_r     <= count_new;
      shown_r     <= shown_new;
    end
  end

  // request flags and output register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      moving_r  <= vehicle_moving;
      stopped_r <= engine_stopped;
      clutch_r  <= clutch_down;
    end
    if (cmd.load) begin
      rep_r   <= shown_new;
      det_r   <= next_gear;
      ratio_r <= ratio;
      unst_r  <= count_new != '0;
    end
  end

  assign reported_gear = rep_r;
  assign detected_gear = det_r;
  assign gear_ratio    = ratio_r;
  assign gear_unstable = unst_r;

  a_unstable_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> unst_r == (count_r != '0))
    else $error("unstable flag disagrees with countdown");

endmodule

// ----- rtl/grd_ctrl.sv -----
// Controller: request accept, divide wait, commit into the output register.
module grd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output grd_pkg::dp_cmd_t cmd,
  input  grd_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd.start = 1'b0;
    cmd.load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divide finished outside the divide state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !cmd.load || !$past(out_valid_r) || out_ready ||
      !out_valid_r || $past(cmd.load))
    else $error("pending result overwritten");

  a_load_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_EVAL && slot_free))
    else $error("load outside evaluate or into a full output register");

endmodule

// ----- rtl/gear_ratio_detector.sv -----
// Flow: request accept, divide, then evaluate and commit into the output register
//   once it is free; a saturated ratio (rpm zero or quotient above 65535) skips
//   the divide iterations. A request is taken only after the last one commits;
//   the serial divider resolves one quotient bit per cycle, 16 bits in all.
// Reset: synchronous active-low rst_n clears windows, reload, calculated gear,
//   countdown and shown gear (neutral); no result pending after reset.
module gear_ratio_detector #(
  parameter int RATIO_SHIFT = grd_pkg::RATIO_SHIFT_DEF,  // 8..16
  parameter int GEAR_COUNT  = grd_pkg::GEAR_COUNT_DEF    // 1..6
) (
  input  logic      clk,
  input  logic      rst_n,
  grd_in_if.sink    in_ch,
  grd_out_if.source out_ch,
  grd_cfg_if.sink   cfg_ch
);

  grd_pkg::dp_cmd_t cmd;
  grd_pkg::dp_sts_t sts;
  logic             cfg_we;

  // Config writes need no wait state, so the port never stalls. Writes to an
  // index past the last register fall through the decode and are dropped.
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  // Controller: a request is taken only when idle; the divider result is then
  // evaluated and committed once the output register is free. The output
  // register decouples the sides, so a new request may be taken while the
  // previous result still waits for the consumer.
  grd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: the start command latches the flags, applies the decay tick to
  // the countdown and launches the divide; the load command picks the gear
  // (outer-window hold, else first inner-window match), reloads the countdown
  // on a change and updates the reported gear.
  grd_dp #(
    .RATIO_SHIFT (RATIO_SHIFT),
    .GEAR_COUNT  (GEAR_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .vehicle_speed  (in_ch.vehicle_speed),
    .engine_speed   (in_ch.engine_speed),
    .vehicle_moving (in_ch.vehicle_moving),
    .engine_stopped (in_ch.engine_stopped),
    .clutch_down    (in_ch.clutch_down),
    .decay_tick     (in_ch.decay_tick),
    .cmd            (cmd),
    .sts            (sts),
    .reported_gear  (out_ch.reported_gear),
    .detected_gear  (out_ch.detected_gear),
    .gear_ratio     (out_ch.gear_ratio),
    .gear_unstable  (out_ch.gear_unstable)
  );

endmodule
